// ===== design/rcsd_pkg.sv =====
// Shared constants, types and configuration codes of the RC stick and gear switch conditioner.
package rcsd_pkg;

  localparam int STICK_COUNT = 4;

  localparam int PULSE_W    = 12;
  localparam int LEVEL_W    = 16;
  localparam int MAG_W      = 15;
  localparam int DZ_W       = 14;
  localparam int GAIN_W     = 15;
  localparam int THR_W      = 12;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int FLAG_COUNT = 6;

  localparam int IN_BITS     = (STICK_COUNT + 1) * PULSE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int RES_W       = STICK_COUNT * LEVEL_W;
  localparam int OUT_BITS    = RES_W + FLAG_COUNT;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;
  localparam int FRAME_W     = STICK_COUNT * PULSE_W;

  // Bit offsets of the gear flags above the stick levels in the output word.
  localparam int FLAG_BASE            = RES_W;
  localparam int FLAG_HOVER_ON        = 0;
  localparam int FLAG_COMMAND_ON      = 1;
  localparam int FLAG_ENTERED_HOVER   = 2;
  localparam int FLAG_ENTERED_COMMAND = 3;
  localparam int FLAG_EXITED_HOVER    = 4;
  localparam int FLAG_EXITED_COMMAND  = 5;

  // Stick scaling: deflection = (p - 1500) / 500 in Q1.15.
  localparam logic [PULSE_W-1:0] CENTER_PULSE = PULSE_W'(1500);
  localparam logic [PULSE_W-1:0] HALF_SPAN    = PULSE_W'(500);

  // Serial division of m * 2^15 + 250 by 500.
  localparam int                   DIV_REM_W = 9;
  localparam logic [DIV_REM_W:0]   DIVISOR   = (DIV_REM_W + 1)'(500);
  localparam logic [MAG_W-1:0]     DIV_ROUND = MAG_W'(250);
  localparam int                   DIV_CNT_W = $clog2(MAG_W + 1);

  // Serial gain multiply, Q1.14 with round to nearest.
  localparam int                PROD_W     = MAG_W + GAIN_W;
  localparam int                FRAC_SHIFT = 14;
  localparam logic [PROD_W-1:0] ROUND_ADD  = PROD_W'(8192);
  localparam int                MUL_CNT_W  = $clog2(GAIN_W + 1);

  localparam logic [MAG_W-1:0] LEVEL_MAX = {MAG_W{1'b1}};

  localparam int STICK_IDX_W = $clog2(STICK_COUNT + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEAD_ZONE   = 2'd0,
    CFG_GAIN        = 2'd1,
    CFG_HOVER_THR   = 2'd2,
    CFG_COMMAND_THR = 2'd3
  } cfg_index_t;

  localparam logic [DZ_W-1:0]   DEAD_ZONE_RESET   = DZ_W'(8192);
  localparam logic [GAIN_W-1:0] GAIN_RESET        = GAIN_W'(21845);
  localparam logic [THR_W-1:0]  HOVER_THR_RESET   = THR_W'(1250);
  localparam logic [THR_W-1:0]  COMMAND_THR_RESET = THR_W'(1750);

  // Packed so that hover_on lands in the lowest bit.
  typedef struct packed {
    logic exited_command;
    logic exited_hover;
    logic entered_command;
    logic entered_hover;
    logic command_on;
    logic hover_on;
  } gear_flags_t;

endpackage

// ===== design/rcsd_serial_div.sv =====
// Restoring divider by 500, one quotient bit per cycle, for the stick magnitude.
module rcsd_serial_div
  import rcsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_REM_W-1:0] dividend_hi,
  output logic                 done,
  output logic [MAG_W-1:0]     quot
);

  logic                 active;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_REM_W-1:0] rem;
  logic [MAG_W-1:0]     low_bits;
  logic [DIV_REM_W:0]   trial;
  logic                 qbit;

  // The low dividend bits shift in from the top of low_bits, one per cycle.
  assign trial = {rem, low_bits[MAG_W-1]};
  assign qbit  = (trial >= DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        count    <= DIV_CNT_W'(MAG_W);
        rem      <= dividend_hi;
        low_bits <= DIV_ROUND;
      end else if (active) begin
        rem      <= qbit ? DIV_REM_W'(trial - DIVISOR) : trial[DIV_REM_W-1:0];
        low_bits <= {low_bits[MAG_W-2:0], 1'b0};
        quot     <= {quot[MAG_W-2:0], qbit};
        count    <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/rcsd_serial_mac.sv =====
// Shift-and-add multiplier, one gain bit per cycle, with the rounding constant preloaded.
module rcsd_serial_mac
  import rcsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  excess,
  input  logic [GAIN_W-1:0] gain,
  output logic              done,
  output logic [PROD_W-1:0] acc
);

  logic                 active;
  logic [MUL_CNT_W-1:0] count;
  logic [PROD_W-1:0]    mcand;
  logic [GAIN_W-1:0]    mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= MUL_CNT_W'(GAIN_W);
        mcand  <= PROD_W'(excess);
        mplier <= gain;
        acc    <= ROUND_ADD;
      end else if (active) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[GAIN_W-1:1]};
        count  <= count - 1'b1;
        if (count == MUL_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/rcsd_gear.sv =====
// Gear switch classification and transition flags against the stored previous position.
module rcsd_gear
  import rcsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_take,
  input  logic [PULSE_W-1:0] gear_pulse,
  input  logic [THR_W-1:0] hover_thr,
  input  logic [THR_W-1:0] command_thr,
  output gear_flags_t      flags
);

  typedef enum logic [1:0] {
    POS_BOTTOM = 2'd0,
    POS_MIDDLE = 2'd1,
    POS_TOP    = 2'd2
  } pos_t;

  pos_t        prev_pos;
  logic        seen_first;
  pos_t        cur_pos;
  pos_t        ref_pos;
  gear_flags_t flags_next;

  always_comb begin
    if (gear_pulse > hover_thr && gear_pulse < command_thr) begin
      cur_pos = POS_MIDDLE;
    end else if (gear_pulse >= command_thr) begin
      cur_pos = POS_TOP;
    end else begin
      cur_pos = POS_BOTTOM;
    end
  end

  // The first frame compares against itself, so it never reports a transition.
  assign ref_pos = seen_first ? prev_pos : cur_pos;

  always_comb begin
    flags_next            = '0;
    flags_next.hover_on   = (cur_pos != POS_BOTTOM);
    flags_next.command_on = (cur_pos == POS_TOP);
    case (cur_pos)
      POS_MIDDLE: begin
        flags_next.entered_hover  = (ref_pos == POS_BOTTOM);
        flags_next.exited_command = (ref_pos == POS_TOP);
      end
      POS_TOP: begin
        flags_next.entered_command = (ref_pos != POS_TOP);
      end
      default: begin
        flags_next.exited_hover   = (ref_pos != POS_BOTTOM);
        flags_next.exited_command = (ref_pos == POS_TOP);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos   <= POS_BOTTOM;
      seen_first <= 1'b0;
    end else if (frame_take) begin
      prev_pos   <= cur_pos;
      seen_first <= 1'b1;
      flags      <= flags_next;
    end
  end

endmodule

// ===== design/rc_stick_deadband_and_switch_edges_unit.sv =====
// Top level: frame intake, per-stick sequencer around the serial divider and multiplier.
//
//  channel  | direction | signals                     | payload
//  ---------+-----------+-----------------------------+---------------------------------------
//  s_*      | in        | s_tvalid, s_tready, s_tdata | stick pulses then gear pulse, 12 b each
//  m_*      | out       | m_tvalid, m_tready, m_tdata | four Q1.15 stick levels, six gear flags
//  cfg_*    | in        | cfg_we, cfg_addr, cfg_wdata | dead zone, gain, two gear thresholds
//
// Sticks are processed one at a time. Each passes through setup, the serial divide by 500
// (skipped when the deflection saturates), a dead-zone compare, the serial gain multiply
// (skipped inside the dead zone) and a store. m_tvalid rises when the result is loaded,
// intake reopens in the same cycle, and one frame is in work at a time.
// A finished result waits in the output register while the next frame is accepted; a frame
// that completes before that result is taken holds until m_tready.
// Reset is synchronous and clears the configuration to its defaults and the switch history.
module rc_stick_deadband_and_switch_edges_unit
  import rcsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // stick0_pulse, stick1_pulse, stick2_pulse, stick3_pulse, gear_pulse, zero padding
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // stick0_level .. stick3_level, hover_on, command_on, entered_hover, entered_command,
  // exited_hover, exited_command, zero padding
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CHECK,
    ST_MUL,
    ST_STORE,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [DZ_W-1:0]        dz_half;
  logic [GAIN_W-1:0]      gain;
  logic [THR_W-1:0]       hover_thr;
  logic [THR_W-1:0]       command_thr;
  logic [FRAME_W-1:0]     frame;
  logic [RES_W-1:0]       res;
  logic [STICK_IDX_W-1:0] stick_idx;
  logic                   neg;
  logic [MAG_W-1:0]       mag;
  logic [MAG_W-1:0]       lvl;

  logic                   frame_take;
  logic                   res_load;
  logic [PULSE_W-1:0]     cur_pulse;
  logic                   cur_neg;
  logic [PULSE_W-1:0]     cur_abs;
  logic                   cur_sat;
  logic                   in_deadband;
  logic [MAG_W-1:0]       excess;
  logic                   div_start;
  logic                   div_done;
  logic [MAG_W-1:0]       div_quot;
  logic                   mul_start;
  logic                   mul_done;
  logic [PROD_W-1:0]      mul_acc;
  logic [MAG_W-1:0]       mul_level;
  logic [LEVEL_W-1:0]     signed_level;
  logic [RES_W+LEVEL_W-1:0] res_shift;
  gear_flags_t            gear_flags;

  assign s_tready   = (state == ST_IDLE);
  assign frame_take = s_tvalid && s_tready;
  assign res_load   = (state == ST_FINISH) && (!m_tvalid || m_tready);

  assign cur_pulse = frame[PULSE_W-1:0];
  assign cur_neg   = (cur_pulse < CENTER_PULSE);
  assign cur_abs   = cur_neg ? CENTER_PULSE - cur_pulse : cur_pulse - CENTER_PULSE;
  // At 500 us or more off center the magnitude reaches full scale without dividing.
  assign cur_sat   = (cur_abs >= HALF_SPAN);
  assign div_start = (state == ST_PREP) && !cur_sat;

  assign in_deadband = (mag <= MAG_W'(dz_half));
  assign excess      = mag - MAG_W'(dz_half);
  assign mul_start   = (state == ST_CHECK) && !in_deadband;

  assign mul_level    = mul_acc[PROD_W-1] ? LEVEL_MAX
                                          : mul_acc[FRAC_SHIFT +: MAG_W];
  assign signed_level = neg ? LEVEL_W'(0) - {1'b0, lvl} : {1'b0, lvl};
  assign res_shift    = {signed_level, res};

  rcsd_serial_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (cur_abs[DIV_REM_W-1:0]),
    .done        (div_done),
    .quot        (div_quot)
  );

  rcsd_serial_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .excess (excess),
    .gain   (gain),
    .done   (mul_done),
    .acc    (mul_acc)
  );

  rcsd_gear u_gear (
    .clk         (clk),
    .rst         (rst),
    .frame_take  (frame_take),
    .gear_pulse  (s_tdata[FRAME_W +: PULSE_W]),
    .hover_thr   (hover_thr),
    .command_thr (command_thr),
    .flags       (gear_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_half     <= DEAD_ZONE_RESET;
      gain        <= GAIN_RESET;
      hover_thr   <= HOVER_THR_RESET;
      command_thr <= COMMAND_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_addr))
        CFG_DEAD_ZONE:   dz_half     <= cfg_wdata[DZ_W-1:0];
        CFG_GAIN:        gain        <= cfg_wdata[GAIN_W-1:0];
        CFG_HOVER_THR:   hover_thr   <= cfg_wdata[THR_W-1:0];
        CFG_COMMAND_THR: command_thr <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stick_idx <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (frame_take) begin
            frame     <= s_tdata[FRAME_W-1:0];
            stick_idx <= '0;
            state     <= ST_PREP;
          end
        end
        ST_PREP: begin
          neg <= cur_neg;
          if (cur_sat) begin
            mag   <= LEVEL_MAX;
            state <= ST_CHECK;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mag   <= div_quot;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (in_deadband) begin
            lvl   <= '0;
            state <= ST_STORE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            lvl   <= mul_level;
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          res   <= res_shift[RES_W+LEVEL_W-1:LEVEL_W];
          frame <= frame >> PULSE_W;
          if (stick_idx == STICK_IDX_W'(STICK_COUNT - 1)) begin
            state <= ST_FINISH;
          end else begin
            stick_idx <= stick_idx + 1'b1;
            state     <= ST_PREP;
          end
        end
        ST_FINISH: begin
          if (res_load) begin
            m_tdata <= {{OUT_PAD_W{1'b0}}, gear_flags, res};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/rcsd_checker.sv =====
// Port-level checks of the conditioner and the bind that attaches them to the top level.
module rcsd_checker
  import rcsd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // One frame is in work at a time, so intake closes right after a transaction.
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a frame was in work");

  // A new result only appears after a frame has been worked on.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result raised without a frame in work");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  a_command_implies_hover: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[FLAG_BASE + FLAG_COMMAND_ON] |-> m_tdata[FLAG_BASE + FLAG_HOVER_ON])
    else $error("command level without hover level");

  // Levels are symmetric, so the most negative code never shows up.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[LEVEL_W-1:0] != {1'b1, {(LEVEL_W-1){1'b0}}})
    else $error("stick level outside its range");

endmodule

bind rc_stick_deadband_and_switch_edges_unit rcsd_checker u_rcsd_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the RC stick dead-zone and gear-switch edge unit.
module testbench;
  import rcsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int DIR_ROWS = 21;
  localparam int RANDOM_PHASES = 12;

  typedef enum logic [1:0] {
    POS_BOTTOM = 2'd0,
    POS_MIDDLE = 2'd1,
    POS_TOP    = 2'd2
  } switch_pos_t;

  typedef struct packed {
    logic [0:STICK_COUNT-1][LEVEL_W-1:0] levels;
    gear_flags_t                         flags;
  } rc_result_t;

  typedef struct packed {
    logic       typed;
    rc_result_t value;
  } hand_result_t;

  // Flag literals below list exited_command down to hover_on, left to right.
  typedef struct packed {
    logic [1:0]                          setting;
    logic [0:STICK_COUNT-1][PULSE_W-1:0] sticks;
    logic [PULSE_W-1:0]                  gear;
    logic                                typed;
    logic [0:STICK_COUNT-1][LEVEL_W-1:0] levels;
    gear_flags_t                         flags;
  } directed_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Local copy of the registers and the switch history.
  logic [DZ_W-1:0]   dz_reg;
  logic [GAIN_W-1:0] gain_reg;
  logic [THR_W-1:0]  hover_thr;
  logic [THR_W-1:0]  command_thr;
  switch_pos_t       last_pos;
  logic              seen_frame;

  rc_result_t   expected_q[$];
  hand_result_t typed_q[$];
  int           fail_count;
  int           quiet_cycles;
  bit           send_calm;
  bit           recv_calm;

  rc_result_t   predicted;
  hand_result_t hand;
  rc_result_t   want;
  logic [FLAG_COUNT-1:0] got_flags;
  logic [FLAG_COUNT-1:0] want_flags;

  string flag_name [FLAG_COUNT] = '{"hover_on", "command_on", "entered_hover",
                                    "entered_command", "exited_hover", "exited_command"};

  logic [CFG_DATA_W-1:0] directed_cfg [4][4] = '{
    '{15'd8192, 15'd21845, 15'd1250, 15'd1750},
    '{15'd0,    15'd16384, 15'd2000, 15'd1000},
    '{15'd16383, 15'd32767, 15'd0,   15'd4095},
    '{15'd0,    15'd32767, 15'd4095, 15'd0}
  };

  directed_row_t frame_table [DIR_ROWS] = '{
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd1000, 1'b1, '{0, 0, 0, 0}, 6'b000000},
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd1500, 1'b1, '{0, 0, 0, 0}, 6'b000101},
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd4095, 1'b1, '{0, 0, 0, 0}, 6'b001011},
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd1500, 1'b1, '{0, 0, 0, 0}, 6'b100001},
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd1250, 1'b1, '{0, 0, 0, 0}, 6'b010000},
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd1750, 1'b1, '{0, 0, 0, 0}, 6'b001011},
    '{2'd0, '{1500, 1500, 1500, 1500}, 12'd0,    1'b1, '{0, 0, 0, 0}, 6'b110000},
    '{2'd0, '{0, 4095, 1000, 2000},    12'd1251, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd0, '{1625, 1375, 1626, 1374}, 12'd1749, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd0, '{1501, 1499, 2730, 1365}, 12'd1750, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd0, '{4095, 0, 1500, 2048},    12'd4095, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd1, '{2000, 1000, 0, 4095},    12'd999,  1'b1,
      '{16'sd32767, -16'sd32767, -16'sd32767, 16'sd32767}, 6'b110000},
    '{2'd1, '{1500, 1500, 1500, 1500}, 12'd1000, 1'b1, '{0, 0, 0, 0}, 6'b001011},
    '{2'd1, '{1500, 1500, 1500, 1500}, 12'd1500, 1'b1, '{0, 0, 0, 0}, 6'b000011},
    '{2'd1, '{1501, 1499, 1750, 1250}, 12'd2000, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd2, '{0, 4095, 2000, 1000},    12'd0,    1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd2, '{1500, 1500, 1500, 1500}, 12'd1,    1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd2, '{3000, 100, 1999, 1001},  12'd4095, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd2, '{2047, 2048, 1023, 1024}, 12'd4094, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd3, '{1510, 1490, 1600, 1400}, 12'd2222, 1'b0, '{0, 0, 0, 0}, 6'b000000},
    '{2'd3, '{1503, 1497, 1550, 1450}, 12'd0,    1'b0, '{0, 0, 0, 0}, 6'b000000}
  };

  rc_stick_deadband_and_switch_edges_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Stick deflection in Q1.15 with the dead zone cut out and the remainder rescaled.
  function automatic logic [LEVEL_W-1:0] stick_level(input logic [PULSE_W-1:0] p);
    logic              neg;
    int unsigned       m;
    int unsigned       mag;
    longint unsigned   scaled;
    logic [LEVEL_W-1:0] lvl;
    neg = p < 1500;
    m = neg ? 1500 - p : p - 1500;
    mag = (m * 32768 + 250) / 500;
    if (mag > 32767) mag = 32767;
    if (mag <= dz_reg) begin
      lvl = '0;
    end else begin
      scaled = (longint'(mag - dz_reg) * gain_reg + 8192) >> 14;
      lvl = (scaled > 32767) ? LEVEL_W'(32767) : LEVEL_W'(scaled);
    end
    if (neg && lvl != 0) lvl = -lvl;
    return lvl;
  endfunction

  function automatic switch_pos_t gear_position(input logic [PULSE_W-1:0] g);
    if (g > hover_thr && g < command_thr) return POS_MIDDLE;
    if (g >= command_thr) return POS_TOP;
    return POS_BOTTOM;
  endfunction

  // Works out the result of one frame and advances the switch history.
  function automatic rc_result_t condition_frame(input logic [IN_TDATA_W-1:0] word);
    rc_result_t  r;
    switch_pos_t cur;
    r = '0;
    for (int i = 0; i < STICK_COUNT; i++) begin
      r.levels[i] = stick_level(word[PULSE_W*i +: PULSE_W]);
    end
    cur = gear_position(word[FRAME_W +: PULSE_W]);
    if (!seen_frame) begin
      seen_frame = 1'b1;
      last_pos = cur;
    end
    r.flags.hover_on = cur != POS_BOTTOM;
    r.flags.command_on = cur == POS_TOP;
    case (cur)
      POS_MIDDLE: begin
        r.flags.entered_hover = last_pos == POS_BOTTOM;
        r.flags.exited_command = last_pos == POS_TOP;
      end
      POS_TOP: begin
        r.flags.entered_command = last_pos != POS_TOP;
      end
      default: begin
        r.flags.exited_hover = last_pos != POS_BOTTOM;
        r.flags.exited_command = last_pos == POS_TOP;
      end
    endcase
    last_pos = cur;
    return r;
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic [PULSE_W-1:0] clamp_pulse(input int p);
    if (p < 0) return '0;
    if (p > 4095) return PULSE_W'(4095);
    return PULSE_W'(p);
  endfunction

  function automatic logic [PULSE_W-1:0] pick_stick();
    int m;
    int p;
    int corner_pulses [5] = '{0, 1499, 1500, 1501, 4095};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = 1500 + int'($urandom_range(0, 1400)) - 700;
      4, 5: begin
        // Land right around the dead-zone boundary.
        m = (int'(dz_reg) * 500) / 32768 + int'($urandom_range(0, 4)) - 2;
        p = $urandom_range(0, 1) ? 1500 + m : 1500 - m;
      end
      6, 7: p = $urandom_range(0, 4095);
      8: p = ($urandom_range(0, 1) ? 2000 : 1000) + int'($urandom_range(0, 6)) - 3;
      default: p = corner_pulses[$urandom_range(0, 4)];
    endcase
    return clamp_pulse(p);
  endfunction

  function automatic logic [PULSE_W-1:0] pick_gear();
    int g;
    case ($urandom_range(0, 6))
      0: g = int'(hover_thr) + int'($urandom_range(0, 2)) - 1;
      1: g = int'(command_thr) + int'($urandom_range(0, 2)) - 1;
      2: g = $urandom_range(0, 4095);
      3: g = $urandom_range(0, hover_thr);
      4, 5: g = $urandom_range(hover_thr, command_thr);
      default: g = $urandom_range(command_thr, 4095);
    endcase
    return clamp_pulse(g);
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_DEAD_ZONE: dz_reg = v[DZ_W-1:0];
      CFG_GAIN:      gain_reg = v[GAIN_W-1:0];
      CFG_HOVER_THR: hover_thr = v[THR_W-1:0];
      default:       command_thr = v[THR_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lowers the frame valid and waits until every pending result has been taken.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input logic [0:STICK_COUNT-1][PULSE_W-1:0] sticks,
                            input logic [PULSE_W-1:0] gear, input hand_result_t typed);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    for (int i = 0; i < STICK_COUNT; i++) word[PULSE_W*i +: PULSE_W] = sticks[i];
    word[FRAME_W +: PULSE_W] = gear;
    gap = draw_gap(send_calm);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_q.push_back(typed);
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] dz;
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] hov;
    logic [CFG_DATA_W-1:0] cmd;
    case ($urandom_range(0, 4))
      0: dz = '0;
      1: dz = CFG_DATA_W'(16383);
      2: dz = CFG_DATA_W'($urandom_range(0, 32767));
      default: dz = CFG_DATA_W'($urandom_range(1000, 14000));
    endcase
    case ($urandom_range(0, 4))
      0: gain = CFG_DATA_W'(16384);
      1: gain = CFG_DATA_W'(32767);
      2: gain = CFG_DATA_W'($urandom_range(0, 16383));
      default: gain = CFG_DATA_W'($urandom_range(16384, 32767));
    endcase
    case ($urandom_range(0, 5))
      0: begin
        hov = CFG_DATA_W'($urandom_range(1500, 4095));
        cmd = CFG_DATA_W'($urandom_range(0, 1500));
      end
      1: begin
        hov = CFG_DATA_W'($urandom_range(1000, 2000));
        cmd = hov;
      end
      2: begin
        hov = '0;
        cmd = CFG_DATA_W'(4095);
      end
      default: begin
        hov = CFG_DATA_W'($urandom_range(900, 1500));
        cmd = CFG_DATA_W'($urandom_range(1500, 2100));
      end
    endcase
    // Bits above a threshold's width must be ignored.
    hov[CFG_DATA_W-1:THR_W] = (CFG_DATA_W-THR_W)'($urandom_range(0, 7));
    cmd[CFG_DATA_W-1:THR_W] = (CFG_DATA_W-THR_W)'($urandom_range(0, 7));
    write_reg(CFG_DEAD_ZONE, dz);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_HOVER_THR, hov);
    write_reg(CFG_COMMAND_THR, cmd);
  endtask

  // Prediction at frame acceptance, checking at result acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted = condition_frame(s_tdata);
        hand = typed_q.pop_front();
        expected_q.push_back(hand.typed ? hand.value : predicted);
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: result 0x%h with no frame pending", $time, m_tdata);
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < STICK_COUNT; i++) begin
            if (m_tdata[LEVEL_W*i +: LEVEL_W] !== want.levels[i]) begin
              fail_count++;
              $display("%0t ns: stick%0d_level expected %0d, actual %0d", $time, i,
                       $signed(want.levels[i]), $signed(m_tdata[LEVEL_W*i +: LEVEL_W]));
            end
          end
          got_flags = m_tdata[FLAG_BASE +: FLAG_COUNT];
          want_flags = want.flags;
          for (int b = 0; b < FLAG_COUNT; b++) begin
            if (got_flags[b] !== want_flags[b]) begin
              fail_count++;
              $display("%0t ns: %s expected %b, actual %b", $time, flag_name[b],
                       want_flags[b], got_flags[b]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall before each transaction.
  initial begin
    int gap;
    wait (rst === 1'b0);
    forever begin
      gap = draw_gap(recv_calm);
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    logic [1:0]                          cur_setting;
    logic [0:STICK_COUNT-1][PULSE_W-1:0] sticks;
    hand_result_t                        typed;
    int                                  count;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_DEAD_ZONE;
    cfg_wdata = '0;
    dz_reg = DEAD_ZONE_RESET;
    gain_reg = GAIN_RESET;
    hover_thr = HOVER_THR_RESET;
    command_thr = COMMAND_THR_RESET;
    last_pos = POS_BOTTOM;
    seen_frame = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    cur_setting = 2'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The first rows run on the register defaults.
    foreach (frame_table[r]) begin
      if (frame_table[r].setting != cur_setting) begin
        cur_setting = frame_table[r].setting;
        settle();
        write_reg(CFG_DEAD_ZONE, directed_cfg[cur_setting][0]);
        write_reg(CFG_GAIN, directed_cfg[cur_setting][1]);
        write_reg(CFG_HOVER_THR, directed_cfg[cur_setting][2]);
        write_reg(CFG_COMMAND_THR, directed_cfg[cur_setting][3]);
      end
      typed.typed = frame_table[r].typed;
      typed.value.levels = frame_table[r].levels;
      typed.value.flags = frame_table[r].flags;
      send_frame(frame_table[r].sticks, frame_table[r].gear, typed);
    end

    typed = '0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      randomize_settings();
      count = $urandom_range(45, 63);
      repeat (count) begin
        for (int i = 0; i < STICK_COUNT; i++) sticks[i] = pick_stick();
        send_frame(sticks, pick_gear(), typed);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
